// ===== hdl/pfb_pkg.sv =====
// pfb_pkg: types, constants, microcode table and port byte table for the
// fan-and-ball pid controller. no dependencies; imported by every other file.
package pfb_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // datapath word, multiplier operand and product widths
  localparam int DW = 56;
  localparam int MW = 34;
  localparam int PW = 2 * MW;

  // exact divide by three for values below 2**32: (x * RECIP3) >> 33
  localparam logic [MW-1:0] RECIP3      = MW'(34'h0AAAAAAAB);
  localparam int            RECIP_SHIFT = 33;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [1:0] CODE_INIT   = 2'd0;
  localparam logic [1:0] CODE_MODE   = 2'd1;
  localparam logic [1:0] CODE_PID    = 2'd2;
  localparam logic [1:0] CODE_MANUAL = 2'd3;

  typedef enum logic [2:0] {
    REG_SETPOINT       = 3'd0,
    REG_GAIN_P         = 3'd1,
    REG_GAIN_I         = 3'd2,
    REG_GAIN_D         = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_DRIVE_MAX      = 3'd5,
    REG_MANUAL_STEP    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] setpoint;
    logic [23:0] gain_p;
    logic [23:0] gain_i;
    logic [23:0] gain_d;
    logic [30:0] integral_limit;
    logic [18:0] drive_max;
    logic [16:0] manual_step;
  } cfg_t;

  typedef struct packed {
    logic mode_pin;
    logic display_select;
    logic raise_button;
    logic lower_button;
  } in_t;

  typedef struct packed {
    logic [7:0]  port_value;
    logic [23:0] position_out;
    logic [18:0] drive_out;
    logic [1:0]  control_state;
  } res_t;

  typedef enum logic [3:0] {
    CS_INIT   = 4'b0001,
    CS_MODE   = 4'b0010,
    CS_PID    = 4'b0100,
    CS_MANUAL = 4'b1000
  } cstate_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_STATE,
    OP_ERRDER,
    OP_INTEG_ADD,
    OP_INTEG_CLAMP,
    OP_DRIVE_CLAMP,
    OP_MAN,
    OP_MAN_CLAMP,
    OP_FAN,
    OP_ACCEL,
    OP_VEL,
    OP_POS,
    OP_PCLAMP,
    OP_PORT
  } op_t;

  typedef enum logic [2:0] {
    M_NONE,
    M_P,
    M_I,
    M_D,
    M_R
  } msel_t;

  typedef enum logic [1:0] {
    AOP_NONE,
    AOP_LOAD,
    AOP_ADD,
    AOP_SUB
  } aop_t;

  typedef enum logic [1:0] {
    C_NEXT,
    C_GOTO,
    C_INIT,
    C_MANUAL
  } cond_t;

  localparam int UPC_W = 5;

  localparam logic [UPC_W-1:0] UA_MAN   = 5'd9;
  localparam logic [UPC_W-1:0] UA_PLANT = 5'd11;
  localparam logic [UPC_W-1:0] UA_DONE  = 5'd19;

  typedef struct packed {
    op_t              op;
    msel_t            msel;
    aop_t             aop;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             last;
  } uword_t;

  typedef struct packed {
    op_t   op;
    msel_t msel;
    aop_t  aop;
    logic  take_in;
    logic  load_out;
  } ctl_t;

  typedef struct packed {
    logic was_init;
    logic manual;
  } stat_t;

  // control store; products pass through the product register and then land in
  // the quotient register after their operands are selected
  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t uw;
    uw = '{op: OP_NOP, msel: M_NONE, aop: AOP_NONE, cond: C_NEXT,
           target: '0, last: 1'b0};
    unique case (pc)
      5'd0: begin
        uw.op = OP_STATE;
        uw.cond = C_INIT;
        uw.target = UA_DONE;
      end
      5'd1: begin
        uw.cond = C_MANUAL;
        uw.target = UA_MAN;
      end
      5'd2:  uw.op = OP_ERRDER;
      5'd3: begin
        uw.op = OP_INTEG_ADD;
        uw.msel = M_P;
      end
      5'd4: begin
        uw.op = OP_INTEG_CLAMP;
        uw.msel = M_D;
      end
      5'd5: begin
        uw.aop = AOP_LOAD;
        uw.msel = M_I;
      end
      5'd6:  uw.aop = AOP_SUB;
      5'd7:  uw.aop = AOP_ADD;
      5'd8: begin
        uw.op = OP_DRIVE_CLAMP;
        uw.cond = C_GOTO;
        uw.target = UA_PLANT;
      end
      5'd9:  uw.op = OP_MAN;
      5'd10: uw.op = OP_MAN_CLAMP;
      5'd11: uw.op = OP_FAN;
      5'd12: uw.msel = M_R;
      5'd13: uw.op = OP_NOP;
      5'd14: uw.op = OP_ACCEL;
      5'd15: uw.op = OP_VEL;
      5'd16: uw.op = OP_POS;
      5'd17: uw.op = OP_PCLAMP;
      5'd18: uw.op = OP_PORT;
      5'd19: uw.last = 1'b1;
      default: uw.last = 1'b1;
    endcase
    return uw;
  endfunction

  function automatic logic [7:0] bar_level(input logic [7:0] n);
    logic [7:0] b;
    if (n <= 8'd26)       b = 8'd128;
    else if (n <= 8'd53)  b = 8'd64;
    else if (n <= 8'd80)  b = 8'd32;
    else if (n <= 8'd106) b = 8'd16;
    else if (n <= 8'd131) b = 8'd8;
    else if (n <= 8'd156) b = 8'd4;
    else if (n <= 8'd181) b = 8'd2;
    else                  b = 8'd1;
    return b;
  endfunction

  function automatic logic [1:0] cs_code(input cstate_t cs);
    logic [1:0] c;
    unique case (cs)
      CS_INIT:   c = CODE_INIT;
      CS_MODE:   c = CODE_MODE;
      CS_PID:    c = CODE_PID;
      CS_MANUAL: c = CODE_MANUAL;
      default:   c = CODE_INIT;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/pfb_if.sv =====
// pfb_item_if, pfb_result_if: valid/ready channels for control ticks and
// their results. depends on pfb_pkg for nothing but the shared naming.
interface pfb_item_if import pfb_pkg::*; ();
  logic valid;
  logic ready;
  logic mode_pin;
  logic display_select;
  logic raise_button;
  logic lower_button;

  modport source (output valid, mode_pin, display_select, raise_button, lower_button,
                  input ready);
  modport sink   (input valid, mode_pin, display_select, raise_button, lower_button,
                  output ready);
endinterface

interface pfb_result_if import pfb_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0]  port_value;
  logic [23:0] position_out;
  logic [18:0] drive_out;
  logic [1:0]  control_state;

  modport source (output valid, port_value, position_out, drive_out, control_state,
                  input ready);
  modport sink   (input valid, port_value, position_out, drive_out, control_state,
                  output ready);
endinterface

// ===== hdl/pfb_apb.sv =====
// pfb_apb: apb register block holding the seven controller settings.
// depends on pfb_pkg (cfg_t, reg_idx_t, ADDR_W, DATA_W).
module pfb_apb import pfb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  localparam logic [23:0] SP_RST  = 24'(64'd100 << FRAC_BITS);
  localparam logic [23:0] GP_RST  = 24'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [23:0] GI_RST  = 24'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [23:0] GD_RST  = 24'(64'd5 << (FRAC_BITS - 1));
  localparam logic [30:0] LIM_RST = 31'(64'd1000 << FRAC_BITS);
  localparam logic [18:0] DM_RST  = 19'(((64'd13 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [16:0] MS_RST  = 17'(((64'd75 << FRAC_BITS) + 64'd5000) / 64'd10000);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint       <= SP_RST;
      cfg.gain_p         <= GP_RST;
      cfg.gain_i         <= GI_RST;
      cfg.gain_d         <= GD_RST;
      cfg.integral_limit <= LIM_RST;
      cfg.drive_max      <= DM_RST;
      cfg.manual_step    <= MS_RST;
    end else if (wr) begin
      unique case (idx)
        REG_SETPOINT:       cfg.setpoint       <= pwdata[23:0];
        REG_GAIN_P:         cfg.gain_p         <= pwdata[23:0];
        REG_GAIN_I:         cfg.gain_i         <= pwdata[23:0];
        REG_GAIN_D:         cfg.gain_d         <= pwdata[23:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= pwdata[30:0];
        REG_DRIVE_MAX:      cfg.drive_max      <= pwdata[18:0];
        REG_MANUAL_STEP:    cfg.manual_step    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SETPOINT:       prdata = DATA_W'(cfg.setpoint);
      REG_GAIN_P:         prdata = DATA_W'(cfg.gain_p);
      REG_GAIN_I:         prdata = DATA_W'(cfg.gain_i);
      REG_GAIN_D:         prdata = DATA_W'(cfg.gain_d);
      REG_INTEGRAL_LIMIT: prdata = DATA_W'(cfg.integral_limit);
      REG_DRIVE_MAX:      prdata = DATA_W'(cfg.drive_max);
      REG_MANUAL_STEP:    prdata = DATA_W'(cfg.manual_step);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== hdl/pfb_seq.sv =====
// pfb_seq: microprogram counter, control store lookup, jumps and the
// channel handshakes. depends on pfb_pkg (ucode, uword_t, ctl_t, stat_t).
module pfb_seq import pfb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctl_t  ctl
);

  logic [UPC_W-1:0] pc;
  logic [UPC_W-1:0] pc_next;
  logic             busy;
  uword_t           uw;
  logic             out_free;

  assign uw       = ucode(pc);
  assign in_ready = !busy;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    ctl.op       = busy ? uw.op : OP_NOP;
    ctl.msel     = busy ? uw.msel : M_NONE;
    ctl.aop      = busy ? uw.aop : AOP_NONE;
    ctl.take_in  = in_valid && !busy;
    // last step waits here until the result register is free
    ctl.load_out = busy && uw.last && out_free;
  end

  always_comb begin
    case (uw.cond)
      C_GOTO:   pc_next = uw.target;
      C_INIT:   pc_next = stat.was_init ? uw.target : pc + UPC_W'(1);
      C_MANUAL: pc_next = stat.manual ? uw.target : pc + UPC_W'(1);
      default:  pc_next = pc + UPC_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.take_in) begin
        busy <= 1'b1;
        pc   <= '0;
      end else if (ctl.load_out) begin
        busy <= 1'b0;
      end else if (busy && !uw.last) begin
        pc <= pc_next;
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/pfb_dp.sv =====
// pfb_dp: controller and plant state, shared multiplier with product and
// quotient registers, accumulator and result register. depends on pfb_pkg.
module pfb_dp import pfb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  in_t   item_d,
  input  ctl_t  ctl,
  output stat_t stat,
  output res_t  res
);

  localparam logic signed [DW-1:0] GRAV      = DW'((64'd98 << FRAC_BITS) / 64'd10);
  localparam logic signed [DW-1:0] PMAX      = DW'(64'd200 << FRAC_BITS);
  localparam logic signed [DW-1:0] DRIVE_RST = DW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [PW-1:0] FMASK = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  cstate_t ctrl;
  in_t     in_r;

  logic signed [DW-1:0] integ, pos, prev, vel, drive;
  logic        [7:0]    port_hold;
  logic signed [DW-1:0] err, der, acc, q;

  logic signed [DW-1:0] setpoint_s, lim_s, dmax_s, step_s, fan;
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod, bias, prod_adj, prod_shf;
  logic                 prod_recip, msel_recip;
  logic        [7:0]    pos_int;
  logic                 up_only, down_only;

  assign setpoint_s = $signed(DW'(cfg.setpoint));
  assign lim_s      = $signed(DW'(cfg.integral_limit));
  assign dmax_s     = $signed(DW'(cfg.drive_max));
  assign step_s     = $signed(DW'(cfg.manual_step));
  assign fan        = drive[DW-1] ? '0 : (drive >>> 1);
  assign pos_int    = pos[FRAC_BITS +: 8];
  assign up_only    = in_r.raise_button && !in_r.lower_button;
  assign down_only  = in_r.lower_button && !in_r.raise_button;

  assign stat.was_init = (ctrl == CS_INIT);
  assign stat.manual   = in_r.mode_pin;

  function automatic logic signed [DW-1:0] clamp_drive(input logic signed [DW-1:0] d,
                                                       input logic signed [DW-1:0] hi);
    logic signed [DW-1:0] r;
    if (d < 0)       r = '0;
    else if (d > hi) r = hi;
    else             r = d;
    return r;
  endfunction

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    msel_recip = 1'b0;
    case (ctl.msel)
      M_P: begin
        ma = $signed(MW'(cfg.gain_p));
        mb = err[MW-1:0];
      end
      M_I: begin
        ma = $signed(MW'(cfg.gain_i));
        mb = integ[MW-1:0];
      end
      M_D: begin
        ma = $signed(MW'(cfg.gain_d));
        mb = der[MW-1:0];
      end
      M_R: begin
        ma = $signed(RECIP3);
        mb = acc[MW-1:0];
        msel_recip = 1'b1;
      end
      default: ;
    endcase
  end

  // products truncate toward zero; the divide-by-three product is never negative
  always_comb begin
    bias     = (prod[PW-1] && !prod_recip) ? $signed(FMASK) : $signed(PW'(0));
    prod_adj = prod + bias;
    prod_shf = prod_recip ? (prod_adj >>> RECIP_SHIFT) : (prod_adj >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    prod       <= PW'(ma) * PW'(mb);
    prod_recip <= msel_recip;
    q          <= prod_shf[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      in_r <= item_d;
    end
    case (ctl.op)
      OP_ERRDER: begin
        err <= setpoint_s - pos;
        der <= pos - prev;
      end
      OP_MAN: begin
        if (up_only)        acc <= drive + step_s;
        else if (down_only) acc <= drive - step_s;
        else                acc <= drive;
      end
      OP_FAN:   acc <= (fan <<< 6) + (fan <<< 5) + (fan <<< 2);
      OP_ACCEL: acc <= q - GRAV;
      OP_POS:   acc <= pos + (vel >>> 1);
      default: begin
        case (ctl.aop)
          AOP_LOAD: acc <= q;
          AOP_ADD:  acc <= acc + q;
          AOP_SUB:  acc <= acc - q;
          default: ;
        endcase
      end
    endcase
    if (ctl.load_out) begin
      res.port_value    <= port_hold;
      res.position_out  <= pos[23:0];
      res.drive_out     <= drive[18:0];
      res.control_state <= cs_code(ctrl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl      <= CS_INIT;
      integ     <= '0;
      pos       <= '0;
      prev      <= '0;
      vel       <= '0;
      drive     <= DRIVE_RST;
      port_hold <= '0;
    end else begin
      case (ctl.op)
        OP_STATE: begin
          if (ctrl == CS_INIT)    ctrl <= CS_MODE;
          else if (in_r.mode_pin) ctrl <= CS_MANUAL;
          else                    ctrl <= CS_PID;
        end
        OP_INTEG_ADD: integ <= integ + err;
        OP_INTEG_CLAMP: begin
          if (integ > lim_s)       integ <= lim_s;
          else if (integ < -lim_s) integ <= -lim_s;
        end
        OP_DRIVE_CLAMP: drive <= clamp_drive(acc, dmax_s);
        OP_MAN_CLAMP: begin
          // both buttons or none leave the drive as it was, unclamped
          if (up_only || down_only) drive <= clamp_drive(acc, dmax_s);
        end
        OP_VEL: vel <= vel + (acc >>> 1);
        OP_PCLAMP: begin
          prev <= pos;
          if (acc < 0) begin
            pos <= '0;
            vel <= '0;
          end else if (acc > PMAX) begin
            pos <= PMAX;
            vel <= '0;
          end else begin
            pos <= acc;
          end
        end
        OP_PORT: port_hold <= in_r.display_select ? bar_level(pos_int) : pos_int;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/pid_fan_ball_controller.sv =====
// pid_fan_ball_controller: top level of the fan-and-ball pid controller.
// depends on pfb_pkg, pfb_if, pfb_apb, pfb_seq, pfb_dp.
//
//   port      kind        dir   carries
//   item      valid/ready in    one control tick: mode pin, display select, buttons
//   result    valid/ready out   port byte, position, drive, control state
//   apb       apb r/w     in    seven settings at byte address 4*i
//
// a tick is accepted only once the previous one has left the microprogram; a pid
// tick skips the manual steps, a manual tick the pid steps, a mode tick goes from
// first to last step; one multiplier with product and quotient registers behind.
// reset is synchronous; nothing is swept afterwards.
// the result sits in its own register, so a tick is accepted while the previous
// result still waits; the sequencer holds at its last step until that result
// is taken.
module pid_fan_ball_controller import pfb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  pfb_item_if.sink          item,
  pfb_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  in_t   item_d;
  ctl_t  ctl;
  stat_t stat;
  res_t  res;

  assign item_d.mode_pin       = item.mode_pin;
  assign item_d.display_select = item.display_select;
  assign item_d.raise_button   = item.raise_button;
  assign item_d.lower_button   = item.lower_button;

  assign result.port_value    = res.port_value;
  assign result.position_out  = res.position_out;
  assign result.drive_out     = res.drive_out;
  assign result.control_state = res.control_state;

  pfb_apb #(.FRAC_BITS(FRAC_BITS)) u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pfb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  pfb_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item_d (item_d),
    .ctl    (ctl),
    .stat   (stat),
    .res    (res)
  );

  // one tick at a time: ready drops after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("tick accepted while another is in progress");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!result.valid || result.ready))
    else $error("result register loaded while a result waits");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(ctl.load_out))
    else $error("result valid without a load");

  // the state leaves init on the first tick, so init is never reported
  a_no_init_report: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.control_state != CODE_INIT))
    else $error("init state reported");

endmodule
